[hdl/psd_pkg.sv]
// ---------------------------------------------------------------------------
// psd_pkg: shared types and constants for the point-to-segment distance block
// Holds the word formats, the CORDIC guard width and the CORDIC gain helper.
// ---------------------------------------------------------------------------
package psd_pkg;

	localparam int COORD_WIDTH       = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int GUARD_BITS        = 12;
	localparam int KINV_FRAC         = 30;
	localparam int DIST_WIDTH        = 17;
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

	// Input word: segment ends and query point, signed Q8.8.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] ax;
		logic signed [COORD_WIDTH-1:0] ay;
		logic signed [COORD_WIDTH-1:0] bx;
		logic signed [COORD_WIDTH-1:0] by;
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [DIST_WIDTH-1:0] distance;
		logic                  outside;
	} out_word_t;

	// Integer square root by the bit-pair method, elaboration time only.
	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned res;
		longint unsigned bt;
		v   = v_in;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// CORDIC gain in Q20, the square root of the squared gain built in Q40.
	function automatic longint unsigned gain_root_q20(input int stages);
		longint unsigned k2;
		k2 = 64'd1 << 40;
		for (int i = 0; i < stages; i++) k2 = k2 + (k2 >> (2 * i));
		return isqrt64(k2);
	endfunction

endpackage

[hdl/psd_cell.sv]
// ---------------------------------------------------------------------------
// psd_cell: one CORDIC micro-rotation stage
// Turns the direction vector toward +x and moves the point vector alike.
// ---------------------------------------------------------------------------
module psd_cell #(
	parameter int W     = 32,
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic                degen_in,
	input  logic signed [W-1:0] xd_in,
	input  logic signed [W-1:0] yd_in,
	input  logic signed [W-1:0] xe_in,
	input  logic signed [W-1:0] ye_in,
	output logic                vld_out,
	output logic                degen_out,
	output logic signed [W-1:0] xd_out,
	output logic signed [W-1:0] yd_out,
	output logic signed [W-1:0] xe_out,
	output logic signed [W-1:0] ye_out
);
	logic signed [W-1:0] xd_n, yd_n, xe_n, ye_n;

	// Rotation direction follows the sign of the direction vector's y.
	always_comb begin
		if (yd_in >= 0) begin
			xd_n = xd_in + (yd_in >>> SHIFT);
			yd_n = yd_in - (xd_in >>> SHIFT);
			xe_n = xe_in + (ye_in >>> SHIFT);
			ye_n = ye_in - (xe_in >>> SHIFT);
		end else begin
			xd_n = xd_in - (yd_in >>> SHIFT);
			yd_n = yd_in + (xd_in >>> SHIFT);
			xe_n = xe_in - (ye_in >>> SHIFT);
			ye_n = ye_in + (xe_in >>> SHIFT);
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			degen_out <= degen_in;
			xd_out    <= xd_n;
			yd_out    <= yd_n;
			xe_out    <= xe_n;
			ye_out    <= ye_n;
		end
	end
endmodule

[hdl/point_segment_distance_top.sv]
// ---------------------------------------------------------------------------
// point_segment_distance_top: perpendicular distance from a point to a segment
// Prepares differences, runs a chain of CORDIC cells, then scales and flags.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid/in_ready   | in_word_t
// out     | output    | out_valid/out_ready | out_word_t
//
// One word is accepted every cycle while the output is not stalled; each word
// passes through CORDIC_STAGES + 4 register stages: one cell
// per micro-rotation plus input, two scaling and output stages.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled output holds every stage in place.
// Reset clears all valid bits; payload registers are not reset.
module point_segment_distance_top #(
	parameter int CORDIC_STAGES = psd_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  psd_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output psd_pkg::out_word_t out_data
);
	import psd_pkg::*;

	// Differences take one bit, the half turn one more, CORDIC growth two.
	localparam int W = COORD_WIDTH + GUARD_BITS + 4;
	localparam int DW = COORD_WIDTH + 2;
	localparam longint unsigned GAIN_Q20 = gain_root_q20(CORDIC_STAGES);
	localparam logic [KINV_FRAC:0] KINV =
		(KINV_FRAC+1)'(((64'd1 << (KINV_FRAC + 20)) + (GAIN_Q20 >> 1)) / GAIN_Q20);
	localparam int SH = KINV_FRAC + GUARD_BITS;
	localparam int PW = W + KINV_FRAC + 1;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Input stage: differences, half turn, guard bits.
	logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, px, py;
	logic signed [DW-1:0] dx, dy, ex, ey, dxh, dyh, exh, eyh;
	assign ax = in_data.ax;
	assign ay = in_data.ay;
	assign bx = in_data.bx;
	assign by = in_data.by;
	assign px = in_data.px;
	assign py = in_data.py;
	always_comb begin
		dx = DW'(bx) - DW'(ax);
		dy = DW'(by) - DW'(ay);
		ex = DW'(px) - DW'(ax);
		ey = DW'(py) - DW'(ay);
		if (dx < 0) begin
			dxh = -dx; dyh = -dy; exh = -ex; eyh = -ey;
		end else begin
			dxh = dx; dyh = dy; exh = ex; eyh = ey;
		end
	end

	logic                vld_c [CORDIC_STAGES+1];
	logic                dg_c  [CORDIC_STAGES+1];
	logic signed [W-1:0] xd_c  [CORDIC_STAGES+1];
	logic signed [W-1:0] yd_c  [CORDIC_STAGES+1];
	logic signed [W-1:0] xe_c  [CORDIC_STAGES+1];
	logic signed [W-1:0] ye_c  [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_c[0] <= 1'b0;
		else if (en) vld_c[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dg_c[0] <= (dx == '0) && (dy == '0);
			xd_c[0] <= W'(dxh) <<< GUARD_BITS;
			yd_c[0] <= W'(dyh) <<< GUARD_BITS;
			xe_c[0] <= W'(exh) <<< GUARD_BITS;
			ye_c[0] <= W'(eyh) <<< GUARD_BITS;
		end
	end

	// Chain of micro-rotation cells.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		psd_cell #(.W(W), .SHIFT(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[i]), .degen_in(dg_c[i]),
			.xd_in(xd_c[i]), .yd_in(yd_c[i]), .xe_in(xe_c[i]), .ye_in(ye_c[i]),
			.vld_out(vld_c[i+1]), .degen_out(dg_c[i+1]),
			.xd_out(xd_c[i+1]), .yd_out(yd_c[i+1]),
			.xe_out(xe_c[i+1]), .ye_out(ye_c[i+1])
		);
	end

	// Decision and magnitude. A degenerate segment needs no turn, yet every
	// cell still turns the point; so its values come from stage zero data
	// carried in guard form.
	localparam int N = CORDIC_STAGES;
	logic signed [W-1:0] xe_f, xd_f, ye_f;
	logic                outside_f;
	logic [W-1:0]        mag_f;
	assign xe_f = xe_c[N];
	assign xd_f = xd_c[N];
	assign ye_f = ye_c[N];
	always_comb begin
		outside_f = ((xe_f < 0) && (xe_f < xd_f)) || ((xe_f > 0) && (xe_f > xd_f));
		mag_f     = (ye_f < 0) ? W'(-ye_f) : W'(ye_f);
	end

	// Degenerate path needs the untouched differences: carry them alongside.
	logic signed [W-1:0] ex0_c [N+1];
	logic signed [W-1:0] ey0_c [N+1];
	assign ex0_c[0] = xe_c[0];
	assign ey0_c[0] = ye_c[0];
	for (genvar j = 0; j < N; j++) begin : g_raw
		always_ff @(posedge clk) begin
			if (en) begin
				ex0_c[j+1] <= ex0_c[j];
				ey0_c[j+1] <= ey0_c[j];
			end
		end
	end

	// Scaling stage one: multiply magnitude by the inverse gain.
	logic            vld_s1, dg_s1, out_s1;
	logic [PW-1:0]   prod_s1;
	logic [W-1:0]    dmag_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld_c[N];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1   <= dg_c[N];
			out_s1  <= dg_c[N] ? (ex0_c[N] != '0) : outside_f;
			prod_s1 <= PW'(mag_f) * PW'(KINV);
			dmag_s1 <= (ey0_c[N] < 0) ? W'(-ey0_c[N]) : W'(ey0_c[N]);
		end
	end

	// Scaling stage two: round, saturate, pick the degenerate path, zero an outside result.
	logic [PW-1:0]         rnd;
	logic [PW-1:0]         dist_w;
	logic [W-1:0]          dgd;
	logic [DIST_WIDTH-1:0] dist_n;
	always_comb begin
		rnd    = (prod_s1 + (PW'(1) << (SH - 1))) >> SH;
		dgd    = dmag_s1 >> GUARD_BITS;
		dist_w = dg_s1 ? PW'(dgd) : rnd;
		if (out_s1) dist_n = '0;
		else if (dist_w > PW'(DIST_MAX)) dist_n = DIST_MAX;
		else dist_n = dist_w[DIST_WIDTH-1:0];
	end

	logic                  vld_s2, out_s2;
	logic [DIST_WIDTH-1:0] dist_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_s2  <= out_s1;
			dist_s2 <= dist_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.distance <= dist_s2;
			out_data.outside  <= out_s2;
		end
	end

	// An outside result always carries zero distance.
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.outside |-> out_data.distance == '0)
		else $error("outside result with nonzero distance");
	// A stalled output holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// Input is ready exactly when the pipeline advances.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow pipeline advance");
endmodule
